[hdl/mop_pkg.sv]
// Package with the types, codes and defaults of the match overlap pair scorer.
package mop_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int SLOT_W          = 6;
    localparam int POS_W           = 31;
    localparam int ID_W            = 32;
    localparam int SCORE_W         = 16;
    localparam int SUM_W           = 25;
    localparam int QUOT_W          = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAFFOLD  = 2'd1;
    localparam logic [POS_W-1:0]     THRESHOLD_RST = 31'd100;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_EMIT  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_KEPT     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_PAIR     = 3'd4;
    localparam logic [2:0] ST_END      = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic [ID_W-1:0]    vertex_id;
        logic [POS_W-1:0]   range_start;
        logic [POS_W-1:0]   range_end;
        logic [SCORE_W-1:0] match_score;
        logic               direction_flag;
        logic               primary_flag;
        logic [ID_W-1:0]    line_number;
        logic [ID_W-1:0]    vertex_order;
        logic [SLOT_W-1:0]  slot_select;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_out;
        logic [ID_W-1:0]   first_vertex;
        logic [ID_W-1:0]   second_vertex;
        logic [POS_W-1:0]  overlap_start;
        logic [POS_W-1:0]  overlap_end;
        logic              same_direction;
        logic              both_primary;
        logic [SUM_W-1:0]  sum_score;
        logic [ID_W-1:0]   pair_line_number;
        logic              last;
    } res_t;

    // Flags: bit 0 direction, bit 1 primary.
    typedef struct packed {
        logic [ID_W-1:0]    vertex_id;
        logic [POS_W-1:0]   range_start;
        logic [POS_W-1:0]   range_end;
        logic [SCORE_W-1:0] score;
        logic [1:0]         flags;
        logic [ID_W-1:0]    line;
        logic [ID_W-1:0]    order;
    } entry_t;

    function automatic res_t res_simple(logic [2:0] status, logic [SLOT_W-1:0] slot,
                                        logic last);
        res_t r;
        r          = '0;
        r.status   = status;
        r.slot_out = slot;
        r.last     = last;
        return r;
    endfunction

endpackage

[hdl/mop_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/match_overlap_pair_scorer.sv]
// Top level of the match overlap pair scorer: slot table, search and pair scoring.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------
//  request   | start, busy              | cmd (cmd_t)
//  result    | res_strobe (one cycle)   | res (res_t)
//  config    | cfg_we                   | cfg_index, cfg_data
//
// A load walks the slots through the table RAM, reading each valid slot and skipping
// each free one, until it meets its vertex id or the end of the table. An emit reads
// its slot, then each lower slot; each qualifying pair passes through the shared
// multiplier and one-bit-per-cycle divider (two terms of 24 quotient bits each).
// A clear drops all valid bits. Reset drops them all at once; the RAM needs no sweep.
// Results cannot be stalled; busy stays high until the final result is shown.
module match_overlap_pair_scorer #(
    parameter int MAX_ENTRIES = mop_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mop_pkg::cmd_t                       cmd,
    output logic                                res_strobe,
    output mop_pkg::res_t                       res,
    input  logic                                cfg_we,
    input  logic [mop_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mop_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam int EW = $bits(mop_pkg::entry_t);

    typedef enum logic [3:0] {
        S_IDLE, S_LD_ADDR, S_LD_CMP, S_ES_RD, S_ES_WAIT, S_EJ_ADDR, S_EJ_CMP,
        S_MUL, S_PRE, S_DIV
    } state_t;

    state_t                       state_reg;
    mop_pkg::cmd_t                cmd_reg;
    logic [MAX_ENTRIES-1:0]       valid_reg;
    logic [mop_pkg::POS_W-1:0]    thr_reg;
    logic [mop_pkg::ID_W-1:0]     scaffold_reg;
    logic [CW-1:0]                cnt_reg;
    logic [AW-1:0]                sidx_reg;
    logic                         free_found_reg;
    logic [AW-1:0]                free_reg;
    mop_pkg::entry_t              s_ent_reg;
    mop_pkg::entry_t              j_ent_reg;
    logic [mop_pkg::POS_W-1:0]    os_reg;
    logic [mop_pkg::POS_W-1:0]    oe_reg;
    logic [31:0]                  common_reg;
    logic                         tsel_reg;
    logic [47:0]                  prod_reg;
    logic [31:0]                  rem_reg;
    logic [mop_pkg::QUOT_W-1:0]   numer_reg;
    logic [mop_pkg::QUOT_W-1:0]   quot_reg;
    logic [4:0]                   step_reg;
    logic [mop_pkg::SUM_W-1:0]    acc_reg;
    logic                         strobe_reg;
    mop_pkg::res_t                res_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [EW-1:0]                ram_rdata_raw;
    mop_pkg::entry_t              ram_rdata;
    mop_pkg::entry_t              new_ent;

    logic [mop_pkg::POS_W-1:0]    cmp_os;
    logic [mop_pkg::POS_W-1:0]    cmp_oe;
    logic                         cmp_hit;
    mop_pkg::entry_t              t_ent;
    logic [31:0]                  t_len;
    logic [32:0]                  div_trial;
    logic [32:0]                  div_diff;
    logic [mop_pkg::SUM_W-1:0]    sum_final;
    logic                         j_first;
    logic                         accept;
    logic                         slot_ok;
    mop_pkg::res_t                pair_res;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign res_strobe = strobe_reg;
    assign res        = res_reg;
    assign ram_rdata  = mop_pkg::entry_t'(ram_rdata_raw);
    assign slot_ok    = (7'(cmd.slot_select) < 7'(MAX_ENTRIES))
                        && valid_reg[cmd.slot_select[AW-1:0]];

    always_comb
    begin
        new_ent             = '0;
        new_ent.vertex_id   = cmd_reg.vertex_id;
        new_ent.range_start = cmd_reg.range_start;
        new_ent.range_end   = cmd_reg.range_end;
        new_ent.score       = cmd_reg.match_score;
        new_ent.flags       = {cmd_reg.primary_flag, cmd_reg.direction_flag};
        new_ent.line        = cmd_reg.line_number;
        new_ent.order       = cmd_reg.vertex_order;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_raddr = cnt_reg[AW-1:0];
        case (state_reg)
            S_LD_ADDR:
            begin
                if (cnt_reg == CW'(MAX_ENTRIES))
                begin
                    ram_we    = free_found_reg;
                    ram_waddr = free_reg;
                end
            end
            S_LD_CMP:
            begin
                ram_we = (ram_rdata.vertex_id == cmd_reg.vertex_id)
                         && (cmd_reg.line_number < ram_rdata.line);
            end
            S_ES_RD:
            begin
                ram_raddr = sidx_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Overlap of the stored slot with the partner just read.
    always_comb
    begin
        cmp_os  = (s_ent_reg.range_start > ram_rdata.range_start) ?
                  s_ent_reg.range_start : ram_rdata.range_start;
        cmp_oe  = (s_ent_reg.range_end < ram_rdata.range_end) ?
                  s_ent_reg.range_end : ram_rdata.range_end;
        cmp_hit = (cmp_os <= cmp_oe) && ((cmp_oe - cmp_os) > thr_reg);
    end

    always_comb
    begin
        t_ent     = tsel_reg ? j_ent_reg : s_ent_reg;
        t_len     = 32'(t_ent.range_end) - 32'(t_ent.range_start) + 32'd1;
        div_trial = {rem_reg, numer_reg[mop_pkg::QUOT_W-1]};
        div_diff  = div_trial - {1'b0, t_len};
        sum_final = acc_reg + mop_pkg::SUM_W'({quot_reg[mop_pkg::QUOT_W-2:0],
                                               !div_diff[32]});
    end

    always_comb
    begin
        if (s_ent_reg.order != j_ent_reg.order)
        begin
            j_first = j_ent_reg.order < s_ent_reg.order;
        end
        else
        begin
            j_first = j_ent_reg.line <= s_ent_reg.line;
        end
        pair_res                  = mop_pkg::res_simple(mop_pkg::ST_PAIR,
                                        mop_pkg::SLOT_W'(cnt_reg), 1'b0);
        pair_res.first_vertex     = j_first ? j_ent_reg.vertex_id : s_ent_reg.vertex_id;
        pair_res.second_vertex    = j_first ? s_ent_reg.vertex_id : j_ent_reg.vertex_id;
        pair_res.overlap_start    = os_reg;
        pair_res.overlap_end      = oe_reg;
        pair_res.same_direction   = (s_ent_reg.flags[0] == j_ent_reg.flags[0]);
        pair_res.both_primary     = s_ent_reg.flags[1] & j_ent_reg.flags[1];
        pair_res.sum_score        = sum_final;
        pair_res.pair_line_number = (s_ent_reg.line > j_ent_reg.line) ?
                                    s_ent_reg.line : j_ent_reg.line;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            thr_reg        <= mop_pkg::THRESHOLD_RST;
            scaffold_reg   <= '0;
            strobe_reg     <= 1'b0;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            tsel_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == mop_pkg::CFG_THRESHOLD)
                begin
                    thr_reg <= cfg_data[mop_pkg::POS_W-1:0];
                end
                else if (cfg_index == mop_pkg::CFG_SCAFFOLD)
                begin
                    scaffold_reg <= cfg_data;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg        <= cmd;
                        cnt_reg        <= '0;
                        free_found_reg <= 1'b0;
                        sidx_reg       <= cmd.slot_select[AW-1:0];
                        if (cmd.action == mop_pkg::ACT_LOAD)
                        begin
                            state_reg <= S_LD_ADDR;
                        end
                        else if (cmd.action == mop_pkg::ACT_EMIT)
                        begin
                            if (slot_ok)
                            begin
                                state_reg <= S_ES_RD;
                            end
                            else
                            begin
                                strobe_reg <= 1'b1;
                                res_reg    <= mop_pkg::res_simple(mop_pkg::ST_END, '0, 1'b1);
                            end
                        end
                        else if (cmd.action == mop_pkg::ACT_CLEAR)
                        begin
                            valid_reg <= '0;
                        end
                    end
                end
                S_LD_ADDR:
                begin
                    if (cnt_reg == CW'(MAX_ENTRIES))
                    begin
                        strobe_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                        if (free_found_reg)
                        begin
                            valid_reg[free_reg] <= 1'b1;
                            res_reg <= mop_pkg::res_simple(mop_pkg::ST_INSERTED,
                                           mop_pkg::SLOT_W'(free_reg), 1'b1);
                        end
                        else
                        begin
                            res_reg <= mop_pkg::res_simple(mop_pkg::ST_FULL, '0, 1'b1);
                        end
                    end
                    else if (!valid_reg[cnt_reg[AW-1:0]])
                    begin
                        if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_reg       <= cnt_reg[AW-1:0];
                        end
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_LD_CMP;
                    end
                end
                S_LD_CMP:
                begin
                    if (ram_rdata.vertex_id == cmd_reg.vertex_id)
                    begin
                        strobe_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                        res_reg    <= mop_pkg::res_simple(
                                          ram_we ? mop_pkg::ST_REPLACED : mop_pkg::ST_KEPT,
                                          mop_pkg::SLOT_W'(cnt_reg), 1'b1);
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= S_LD_ADDR;
                    end
                end
                S_ES_RD:
                begin
                    state_reg <= S_ES_WAIT;
                end
                S_ES_WAIT:
                begin
                    s_ent_reg <= ram_rdata;
                    state_reg <= S_EJ_ADDR;
                end
                S_EJ_ADDR:
                begin
                    if (cnt_reg == {1'b0, sidx_reg})
                    begin
                        strobe_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                        res_reg    <= mop_pkg::res_simple(mop_pkg::ST_END, '0, 1'b1);
                    end
                    else if (!valid_reg[cnt_reg[AW-1:0]])
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_EJ_CMP;
                    end
                end
                S_EJ_CMP:
                begin
                    if (cmp_hit)
                    begin
                        j_ent_reg  <= ram_rdata;
                        os_reg     <= cmp_os;
                        oe_reg     <= cmp_oe;
                        common_reg <= 32'(cmp_oe - cmp_os) + 32'd1;
                        tsel_reg   <= 1'b0;
                        acc_reg    <= '0;
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= S_EJ_ADDR;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= 48'(t_ent.score) * 48'(common_reg);
                    state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    // The quotient stays below 2^24, so the top bits start the remainder.
                    rem_reg   <= prod_reg[47:16];
                    numer_reg <= {prod_reg[15:0], 8'h00};
                    quot_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg   <= div_diff[32] ? div_trial[31:0] : div_diff[31:0];
                    quot_reg  <= {quot_reg[mop_pkg::QUOT_W-2:0], !div_diff[32]};
                    numer_reg <= {numer_reg[mop_pkg::QUOT_W-2:0], 1'b0};
                    step_reg  <= step_reg + 5'd1;
                    if (step_reg == 5'(mop_pkg::QUOT_W - 1))
                    begin
                        if (!tsel_reg)
                        begin
                            acc_reg   <= sum_final;
                            tsel_reg  <= 1'b1;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            strobe_reg <= 1'b1;
                            res_reg    <= pair_res;
                            cnt_reg    <= cnt_reg + CW'(1);
                            state_reg  <= S_EJ_ADDR;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    mop_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (EW'(new_ent)),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

`ifndef NO_ASSERTIONS
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.last |-> !busy)
        else $error("final result shown while still busy");

    a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && !res.last |-> busy && res.status == mop_pkg::ST_PAIR)
        else $error("non-final result that is not a pair");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.action == mop_pkg::ACT_LOAD |=> busy && !res_strobe)
        else $error("load did not start its slot search");

    a_pair_thr: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.status == mop_pkg::ST_PAIR |->
        res.overlap_end - res.overlap_start > thr_reg)
        else $error("pair emitted below the overlap threshold");
`endif

endmodule
